// ===== rtl/dtfp_pkg.sv =====
package dtfp_pkg;

    // Fraction digits kept in the scaled result (0 to 18).
    localparam int DECIMALS = 8;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 64;
    localparam int MAG_W   = 63;
    localparam int FC_W    = 5;
    localparam int SUM_W   = MAG_W + 5;

    localparam logic [FC_W-1:0] DEC_CNT = FC_W'(DECIMALS);

    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        PH_START = 3'b001,
        PH_INT   = 3'b010,
        PH_FRAC  = 3'b100
    } t_phase;

    // Powers of ten, 10^0 through 10^18.
    localparam logic [VALUE_W-1:0] POW10 [0:18] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000,
        64'd100000000000000000,
        64'd1000000000000000000
    };

endpackage

// ===== rtl/decimal_text_to_fixed_point_core.sv =====
// Decimal text to fixed point. Feed the characters of a decimal number, one
// byte per beat, then a beat with i_end_of_text set; that closing beat yields
// one result beat: o_parse_ok and o_fixed_value = number * 10^DECIMALS in two's
// complement (0 when the parse fails). Accepted text: an optional leading '+'
// or '-', integer digits, an optional '.' and fraction digits. Fraction digits
// beyond DECIMALS are dropped, missing ones count as zeros. Failure: any other
// byte, a sign that is not first, a second point, no digit at all, or a value
// above 2^63-1 after scaling. Character beats produce no result. Throughput is
// one beat per cycle while o_stall is low; an end-marker result is registered
// in the output register, or the skid entry if that is held. The accumulator
// is kept already scaled by the pending power of ten, so each character costs
// one multiply-by-ten (two shifted adds) plus a digit-times-constant add on a
// 68-bit sum; that add sets the clock. A two-entry output stage (output
// register plus skid) raises o_stall only once a result is parked in the skid.
module decimal_text_to_fixed_point_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // character channel
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic        [dtfp_pkg::BYTE_W-1:0]    i_text_byte,
    input  logic                                  i_end_of_text,
    // result channel
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic                                  o_parse_ok,
    output logic signed [dtfp_pkg::VALUE_W-1:0]   o_fixed_value
);
    import dtfp_pkg::*;

    // parse state
    t_phase             r_phase;
    logic               r_neg;
    logic [MAG_W-1:0]   r_scaled;     // mantissa * 10^(DECIMALS - fraction count)
    logic [FC_W-1:0]    r_frac_count;
    logic               r_seen;
    logic               r_failed;
    logic               r_over;       // scaled value ever exceeded 2^63-1

    // output register and skid entry
    logic               r_out_v;
    logic               r_out_ok;
    logic [VALUE_W-1:0] r_out_val;
    logic               r_skid_v;
    logic               r_skid_ok;
    logic [VALUE_W-1:0] r_skid_val;

    logic               w_acc;
    logic               w_res_v;
    logic               w_out_free;
    logic               w_is_digit;
    logic               w_is_sign;
    logic               w_is_point;
    logic               w_pre_frac;
    logic               w_frac_room;
    logic [3:0]         w_digit;
    logic [FC_W-1:0]    w_idx;
    logic [VALUE_W-1:0] w_place;
    logic [SUM_W-1:0]   w_base;
    logic [SUM_W-1:0]   w_addend;
    logic [SUM_W-1:0]   w_sum;
    logic               w_take;
    logic               w_ok;
    logic [VALUE_W-1:0] w_mag;
    logic [VALUE_W-1:0] w_val;

    // Accept while the skid entry is empty; a result beat needs at most it.
    assign o_stall    = r_skid_v;
    assign w_acc      = i_valid && !r_skid_v;
    assign w_res_v    = w_acc && i_end_of_text;
    assign w_out_free = !r_out_v || !i_stall;

    // Character class.
    assign w_is_digit = (i_text_byte >= CH_ZERO) && (i_text_byte <= CH_NINE);
    assign w_is_sign  = (i_text_byte == CH_MINUS) || (i_text_byte == CH_PLUS);
    assign w_is_point = (i_text_byte == CH_POINT);
    assign w_digit    = 4'(i_text_byte - CH_ZERO);

    // Phase codes other than start and integer behave as the fraction part.
    assign w_pre_frac  = (r_phase == PH_START) || (r_phase == PH_INT);
    assign w_frac_room = r_frac_count < DEC_CNT;
    assign w_idx       = w_frac_room ? (DEC_CNT - FC_W'(1) - r_frac_count) : '0;

    // Integer digit:  scaled*10 + d*10^DECIMALS.
    // Fraction digit: scaled    + d*10^(DECIMALS-1-count).
    always_comb begin
        if (w_pre_frac) begin
            w_base  = {2'b0, r_scaled, 3'b0} + {4'b0, r_scaled, 1'b0};
            w_place = POW10[DECIMALS];
        end else begin
            w_base  = {5'b0, r_scaled};
            w_place = POW10[w_idx];
        end
        w_addend = (w_digit[3] ? {1'b0, w_place, 3'b0} : SUM_W'(0))
                 + (w_digit[2] ? {2'b0, w_place, 2'b0} : SUM_W'(0))
                 + (w_digit[1] ? {3'b0, w_place, 1'b0} : SUM_W'(0))
                 + (w_digit[0] ? {4'b0, w_place}       : SUM_W'(0));
        w_sum    = w_base + w_addend;
    end

    // A digit updates the accumulator unless it is a surplus fraction digit.
    assign w_take = w_is_digit && (w_pre_frac || w_frac_room);

    // Result of the closing beat.
    assign w_ok  = !r_failed && r_seen && !r_over;
    assign w_mag = {1'b0, r_scaled};
    always_comb begin
        if (!w_ok) begin
            w_val = '0;
        end else if (r_neg) begin
            w_val = (~w_mag) + VALUE_W'(1);
        end else begin
            w_val = w_mag;
        end
    end

    // Parse state: advance on each character, clear on the end marker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_neg        <= 1'b0;
            r_scaled     <= '0;
            r_frac_count <= '0;
            r_seen       <= 1'b0;
            r_failed     <= 1'b0;
            r_over       <= 1'b0;
        end else if (w_acc) begin
            if (i_end_of_text) begin
                r_phase      <= PH_START;
                r_neg        <= 1'b0;
                r_scaled     <= '0;
                r_frac_count <= '0;
                r_seen       <= 1'b0;
                r_failed     <= 1'b0;
                r_over       <= 1'b0;
            end else if (!r_failed) begin
                priority if (w_is_digit) begin
                    r_seen <= 1'b1;
                    if (w_pre_frac) begin
                        r_phase <= PH_INT;
                    end
                    if (w_take) begin
                        r_scaled <= w_sum[MAG_W-1:0];
                        if (w_sum[SUM_W-1:MAG_W] != '0) begin
                            r_over <= 1'b1;
                        end
                        if (!w_pre_frac) begin
                            r_frac_count <= r_frac_count + FC_W'(1);
                        end
                    end
                end else if (w_is_sign) begin
                    if (r_phase == PH_START) begin
                        r_neg   <= (i_text_byte == CH_MINUS);
                        r_phase <= PH_INT;
                    end else begin
                        r_failed <= 1'b1;
                    end
                end else if (w_is_point) begin
                    if (w_pre_frac) begin
                        r_phase <= PH_FRAC;
                    end else begin
                        r_failed <= 1'b1;
                    end
                end else begin
                    r_failed <= 1'b1;
                end
            end
        end
    end

    // Output stage control: drain skid first, park a result if output is held.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_out_free) begin
            r_out_v  <= r_skid_v || w_res_v;
            r_skid_v <= 1'b0;
        end else if (w_res_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // Output stage payload.
    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_v) begin
                r_out_ok  <= r_skid_ok;
                r_out_val <= r_skid_val;
            end else if (w_res_v) begin
                r_out_ok  <= w_ok;
                r_out_val <= w_val;
            end
        end else if (w_res_v) begin
            r_skid_ok  <= w_ok;
            r_skid_val <= w_val;
        end
    end

    assign o_valid       = r_out_v;
    assign o_parse_ok    = r_out_ok;
    assign o_fixed_value = r_out_val;

endmodule
